// ===== design/fdsa_pkg.sv =====
package fdsa_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int WORD_WIDTH_DEF  = 32;

   localparam int OP_W     = 5;
   localparam int STATUS_W = 2;
   localparam int KIND_W   = 2;

   // forth words
   localparam logic [OP_W-1:0] OP_DROP = 5'd0;
   localparam logic [OP_W-1:0] OP_DUP  = 5'd1;
   localparam logic [OP_W-1:0] OP_SWAP = 5'd2;
   localparam logic [OP_W-1:0] OP_ROT  = 5'd3;
   localparam logic [OP_W-1:0] OP_OVER = 5'd4;
   localparam logic [OP_W-1:0] OP_ADD  = 5'd5;
   localparam logic [OP_W-1:0] OP_SUB  = 5'd6;
   localparam logic [OP_W-1:0] OP_MUL  = 5'd7;
   localparam logic [OP_W-1:0] OP_DIV  = 5'd8;
   localparam logic [OP_W-1:0] OP_MOD  = 5'd9;
   localparam logic [OP_W-1:0] OP_GT   = 5'd10;
   localparam logic [OP_W-1:0] OP_LT   = 5'd11;
   localparam logic [OP_W-1:0] OP_EQ   = 5'd12;
   localparam logic [OP_W-1:0] OP_DOT  = 5'd13;
   localparam logic [OP_W-1:0] OP_EMIT = 5'd14;
   localparam logic [OP_W-1:0] OP_CR   = 5'd15;
   localparam logic [OP_W-1:0] OP_PUSH = 5'd16;

   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_DIVZERO   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd3;

   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NUMBER  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CHAR    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NEWLINE = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_LOAD,
      S_ROT,
      S_EXEC,
      S_WRITE2,
      S_MUL,
      S_NEGA,
      S_NEGB,
      S_DIV,
      S_FIX,
      S_RESULT,
      S_DONE
   } seq_state_type;

endpackage

// ===== design/forth_data_stack_alu_core.sv =====
// a beat is checked first; refused words, newline and unknown words go straight to the result,
// others load their operands (rot in an extra state) and execute, swap and rot with a second
// write; a zero divisor ends at execute. The next beat is taken only after the result of the
// last one is registered, one word at a time, as the stack memory has a single write port and
// the shared adder multiplies and divides one bit per cycle.
// reset is synchronous and empties the stack; the stack memory itself is not cleared.
module forth_data_stack_alu_core
   import fdsa_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int WORD_WIDTH  = WORD_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,

   input  logic req_tvalid,
   output logic req_tready,
   // literal
   input  logic [((WORD_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   // op
   input  logic [OP_W-1:0] req_tuser,

   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_value, depth_after
   output logic [((WORD_WIDTH + $clog2(STACK_DEPTH + 1) + 7) / 8) * 8 - 1:0] rsp_tdata,
   // status, out_kind
   output logic [STATUS_W+KIND_W-1:0] rsp_tuser
);

   localparam int WW = WORD_WIDTH;
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int SW = $clog2(WORD_WIDTH);
   localparam int RSP_DATA_W = ((WORD_WIDTH + CW + 7) / 8) * 8;

   seq_state_type state_ff, state_in;

   logic [OP_W-1:0]     op_ff, op_in;
   logic [WW-1:0]       lit_ff, lit_in;
   logic [WW-1:0]       x_ff, x_in;
   logic [WW-1:0]       y_ff, y_in;
   logic [WW-1:0]       acc_ff, acc_in;
   logic [SW-1:0]       step_ff, step_in;
   logic                neg_q_ff, neg_q_in;
   logic                neg_r_ff, neg_r_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [WW-1:0]       value_ff, value_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [WW-1:0]       rsp_value_ff, rsp_value_in;
   logic [CW-1:0]       rsp_count_ff, rsp_count_in;

   logic [WW-1:0] stack_mem [STACK_DEPTH];
   logic [WW-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0] rd_a_addr, rd_b_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [WW-1:0] wr_data;

   // shared adder, wide enough for signed compares and divider trial subtracts
   logic [WW:0] add_x, add_y, add_sum;
   logic        add_inv;

   logic [CW-1:0] cnt_p1, cnt_m1, cnt_m2, cnt_m3;
   logic [1:0]    need;
   logic          grows, underflow, overflow, chk_refuse, last_step, slot_free, qbit;

   assign add_sum = add_x + (add_y ^ {(WW + 1){add_inv}}) + (WW + 1)'(add_inv);

   assign cnt_p1 = count_ff + CW'(1);
   assign cnt_m1 = count_ff - CW'(1);
   assign cnt_m2 = count_ff - CW'(2);
   assign cnt_m3 = count_ff - CW'(3);

   always_comb begin
      case (op_ff)
         OP_DROP, OP_DUP, OP_DOT, OP_EMIT: need = 2'd1;
         OP_ROT: need = 2'd3;
         OP_SWAP, OP_OVER, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_GT, OP_LT, OP_EQ:
            need = 2'd2;
         default: need = 2'd0;
      endcase
   end

   assign grows      = op_ff inside {OP_DUP, OP_OVER, OP_PUSH};
   assign underflow  = count_ff < CW'(need);
   assign overflow   = grows && (count_ff == CW'(STACK_DEPTH));
   assign chk_refuse = underflow || overflow;
   assign last_step  = step_ff == SW'(WW - 1);
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_count_ff, rsp_value_ff});
   assign rsp_tuser  = {rsp_kind_ff, rsp_status_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (chk_refuse || op_ff == OP_CR || op_ff > OP_PUSH) state_in = S_DONE;
            else state_in = S_LOAD;
         end
         S_LOAD: begin
            state_in = (op_ff == OP_ROT) ? S_ROT : S_EXEC;
         end
         S_ROT: state_in = S_EXEC;
         S_EXEC: begin
            case (op_ff)
               OP_SWAP, OP_ROT: state_in = S_WRITE2;
               OP_MUL: state_in = S_MUL;
               OP_DIV, OP_MOD: state_in = (y_ff == '0) ? S_DONE : S_NEGA;
               default: state_in = S_DONE;
            endcase
         end
         S_WRITE2: state_in = S_DONE;
         S_MUL: begin
            if (last_step) state_in = S_RESULT;
         end
         S_NEGA: state_in = S_NEGB;
         S_NEGB: state_in = S_DIV;
         S_DIV: begin
            if (last_step) state_in = S_FIX;
         end
         S_FIX: state_in = S_RESULT;
         S_RESULT: state_in = S_DONE;
         S_DONE: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // adder operand select
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_inv = 1'b0;
      case (state_ff)
         S_EXEC: begin
            add_x   = {x_ff[WW-1], x_ff};
            add_y   = {y_ff[WW-1], y_ff};
            add_inv = (op_ff != OP_ADD);
         end
         S_MUL: begin
            // shift-add, low word only
            add_x = {1'b0, acc_ff};
            add_y = y_ff[0] ? {1'b0, x_ff} : '0;
         end
         S_NEGA: begin
            add_y   = {1'b0, x_ff};
            add_inv = 1'b1;
         end
         S_NEGB: begin
            add_y   = {1'b0, y_ff};
            add_inv = 1'b1;
         end
         S_DIV: begin
            // restoring step: remainder stays below the divisor magnitude
            add_x   = {1'b0, acc_ff[WW-2:0], x_ff[WW-1]};
            add_y   = {1'b0, y_ff};
            add_inv = 1'b1;
         end
         S_FIX: begin
            add_y   = {1'b0, (op_ff == OP_DIV) ? x_ff : acc_ff};
            add_inv = (op_ff == OP_DIV) ? neg_q_ff : neg_r_ff;
         end
         default: ;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in         = op_ff;
      lit_in        = lit_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      acc_in        = acc_ff;
      step_in       = step_ff;
      neg_q_in      = neg_q_ff;
      neg_r_in      = neg_r_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rd_a_addr     = cnt_m1[AW-1:0];
      rd_b_addr     = cnt_m2[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = cnt_m1[AW-1:0];
      wr_data       = y_ff;
      qbit          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in  = req_tuser;
               lit_in = req_tdata[WW-1:0];
            end
         end
         S_CHECK: begin
            value_in = '0;
            kind_in  = (op_ff == OP_CR) ? KIND_NEWLINE : KIND_NONE;
            if (underflow) status_in = STAT_UNDERFLOW;
            else if (overflow) status_in = STAT_OVERFLOW;
            else status_in = STAT_OK;
         end
         S_LOAD: begin
            x_in = rd_b_ff;
            y_in = rd_a_ff;
            // third element for rot
            if (op_ff == OP_ROT) rd_a_addr = cnt_m3[AW-1:0];
         end
         S_ROT: begin
            wr_en   = 1'b1;
            wr_addr = cnt_m1[AW-1:0];
            wr_data = rd_a_ff;
         end
         S_EXEC: begin
            case (op_ff)
               OP_DROP: count_in = cnt_m1;
               OP_DOT: begin
                  kind_in  = KIND_NUMBER;
                  value_in = y_ff;
                  count_in = cnt_m1;
               end
               OP_EMIT: begin
                  kind_in  = KIND_CHAR;
                  value_in = WW'(y_ff[7:0]);
                  count_in = cnt_m1;
               end
               OP_DUP, OP_OVER, OP_PUSH: begin
                  wr_en   = 1'b1;
                  wr_addr = count_ff[AW-1:0];
                  if (op_ff == OP_DUP) wr_data = y_ff;
                  else if (op_ff == OP_OVER) wr_data = x_ff;
                  else wr_data = lit_ff;
                  count_in = cnt_p1;
               end
               OP_SWAP: begin
                  wr_en   = 1'b1;
                  wr_addr = cnt_m1[AW-1:0];
                  wr_data = x_ff;
               end
               OP_ROT: begin
                  wr_en   = 1'b1;
                  wr_addr = cnt_m3[AW-1:0];
                  wr_data = x_ff;
               end
               OP_ADD, OP_SUB, OP_GT, OP_LT, OP_EQ: begin
                  wr_en    = 1'b1;
                  wr_addr  = cnt_m2[AW-1:0];
                  count_in = cnt_m1;
                  case (op_ff)
                     OP_GT: wr_data = {WW{!add_sum[WW] && (add_sum != '0)}};
                     OP_LT: wr_data = {WW{add_sum[WW]}};
                     OP_EQ: wr_data = {WW{add_sum == '0}};
                     default: wr_data = add_sum[WW-1:0];
                  endcase
               end
               OP_MUL: begin
                  acc_in  = '0;
                  step_in = '0;
               end
               OP_DIV, OP_MOD: begin
                  if (y_ff == '0) begin
                     status_in = STAT_DIVZERO;
                     count_in  = cnt_m2;
                  end else begin
                     acc_in   = '0;
                     step_in  = '0;
                     neg_q_in = x_ff[WW-1] ^ y_ff[WW-1];
                     neg_r_in = x_ff[WW-1];
                  end
               end
               default: ;
            endcase
         end
         S_WRITE2: begin
            wr_en   = 1'b1;
            wr_addr = cnt_m2[AW-1:0];
            wr_data = y_ff;
         end
         S_MUL: begin
            acc_in  = add_sum[WW-1:0];
            x_in    = x_ff << 1;
            y_in    = y_ff >> 1;
            step_in = step_ff + SW'(1);
         end
         S_NEGA: begin
            if (x_ff[WW-1]) x_in = add_sum[WW-1:0];
         end
         S_NEGB: begin
            if (y_ff[WW-1]) y_in = add_sum[WW-1:0];
         end
         S_DIV: begin
            qbit    = !add_sum[WW];
            acc_in  = qbit ? add_sum[WW-1:0] : add_x[WW-1:0];
            x_in    = {x_ff[WW-2:0], qbit};
            step_in = step_ff + SW'(1);
         end
         S_FIX: begin
            acc_in = add_sum[WW-1:0];
         end
         S_RESULT: begin
            wr_en    = 1'b1;
            wr_addr  = cnt_m2[AW-1:0];
            wr_data  = acc_ff;
            count_in = cnt_m1;
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_kind_in   = kind_ff;
               rsp_value_in  = value_ff;
               rsp_count_in  = count_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      lit_ff        <= lit_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      acc_ff        <= acc_in;
      step_ff       <= step_in;
      neg_q_ff      <= neg_q_in;
      neg_r_ff      <= neg_r_in;
      status_ff     <= status_in;
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // stack memory, one write port and two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) stack_mem[wr_addr] <= wr_data;
      rd_a_ff <= stack_mem[rd_a_addr];
      rd_b_ff <= stack_mem[rd_b_addr];
   end

`ifndef SYNTH
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (int'(wr_addr) < STACK_DEPTH))
      else $error("stack write outside memory");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (y_ff != '0))
      else $error("divider running on zero divisor");

   a_refuse_keeps_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && chk_refuse) |=> (count_ff == $past(count_ff)))
      else $error("refused word changed stack depth");

   a_rsp_depth_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff <= CW'(STACK_DEPTH)))
      else $error("reported depth beyond stack size");
`endif

endmodule

// ===== tb/testbench.sv =====
module testbench;
   import fdsa_pkg::*;

   localparam int STACK_DEPTH = STACK_DEPTH_DEF;
   localparam int WORD_WIDTH  = WORD_WIDTH_DEF;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int REQ_DATA_W  = ((WORD_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((WORD_WIDTH + DEPTH_W + 7) / 8) * 8;

   localparam logic [OP_W-1:0] OP_UNKNOWN_FIRST = 5'd17;
   localparam logic [OP_W-1:0] OP_UNKNOWN_LAST  = 5'd31;

   localparam int NUM_DIRECTED     = 25;
   localparam int NUM_PHASES       = 4;
   localparam int RANDOM_PER_PHASE = 150;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int DRAIN_CYCLES     = 60;
   localparam int MAX_REPORTS      = 10;

   typedef logic [WORD_WIDTH-1:0] word_t;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [KIND_W-1:0]   kind;
      word_t               value;
      logic [DEPTH_W-1:0]  depth;
   } word_result_t;

   typedef struct packed {
      logic [OP_W-1:0] op;
      word_t           lit;
      logic            typed_in;
      word_result_t    res;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // literal
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // op
   logic [OP_W-1:0]       req_tuser = '0;

   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   // out_value, depth_after
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // status, out_kind
   logic [STATUS_W+KIND_W-1:0] rsp_tuser;

   forth_data_stack_alu_core #(
      .STACK_DEPTH (STACK_DEPTH),
      .WORD_WIDTH  (WORD_WIDTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the data stack
   word_t stack_mem [STACK_DEPTH];
   int    stack_depth = 0;

   word_result_t expected_results [$];
   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int idle_cycles    = 0;

   int send_pct  [NUM_PHASES] = '{0, 53, 0, 13};
   int stall_pct [NUM_PHASES] = '{0, 0, 53, 13};

   stim_row_t directed_rows [NUM_DIRECTED] = '{
      '{OP_DROP, 32'h0, 1'b1, '{STAT_UNDERFLOW, KIND_NONE, 32'h0, 7'd0}},
      '{OP_DOT, 32'h0, 1'b1, '{STAT_UNDERFLOW, KIND_NONE, 32'h0, 7'd0}},
      '{OP_CR, 32'hFFFFFFFF, 1'b1, '{STAT_OK, KIND_NEWLINE, 32'h0, 7'd0}},
      '{OP_UNKNOWN_LAST, 32'h12345678, 1'b1, '{STAT_OK, KIND_NONE, 32'h0, 7'd0}},
      '{OP_PUSH, 32'h80000000, 1'b1, '{STAT_OK, KIND_NONE, 32'h0, 7'd1}},
      '{OP_PUSH, 32'hFFFFFFFF, 1'b1, '{STAT_OK, KIND_NONE, 32'h0, 7'd2}},
      // most negative over minus one
      '{OP_DIV, 32'h0, 1'b0, '0},
      '{OP_PUSH, 32'hFFFFFFFF, 1'b0, '0},
      '{OP_MOD, 32'h0, 1'b0, '0},
      '{OP_PUSH, 32'h0, 1'b0, '0},
      '{OP_DIV, 32'h0, 1'b1, '{STAT_DIVZERO, KIND_NONE, 32'h0, 7'd0}},
      '{OP_PUSH, 32'h7FFFFFFF, 1'b0, '0},
      '{OP_DUP, 32'h0, 1'b0, '0},
      '{OP_ADD, 32'h0, 1'b0, '0},
      '{OP_PUSH, 32'h000001FF, 1'b0, '0},
      '{OP_OVER, 32'h0, 1'b0, '0},
      '{OP_ROT, 32'h0, 1'b0, '0},
      '{OP_MUL, 32'h0, 1'b0, '0},
      '{OP_SWAP, 32'h0, 1'b0, '0},
      '{OP_SUB, 32'h0, 1'b0, '0},
      '{OP_PUSH, 32'h000001FF, 1'b0, '0},
      '{OP_EMIT, 32'h0, 1'b0, '0},
      '{OP_DUP, 32'h0, 1'b0, '0},
      '{OP_EQ, 32'h0, 1'b0, '0},
      '{OP_DOT, 32'h0, 1'b0, '0}
   };

   function automatic word_result_t predict_word(input logic [OP_W-1:0] op, input word_t lit);
      word_result_t res;
      int           need;
      word_t        tos, nos, third, r;
      longint       num, den;
      res = '0;
      case (op)
         OP_DROP, OP_DUP, OP_DOT, OP_EMIT: need = 1;
         OP_ROT: need = 3;
         OP_SWAP, OP_OVER, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
         OP_GT, OP_LT, OP_EQ: need = 2;
         default: need = 0;
      endcase
      if (op > OP_PUSH) begin
         // unknown words leave everything alone
      end else if (stack_depth < need) begin
         res.status = STAT_UNDERFLOW;
      end else if ((op == OP_DUP || op == OP_OVER || op == OP_PUSH) &&
                   stack_depth >= STACK_DEPTH) begin
         res.status = STAT_OVERFLOW;
      end else begin
         tos = (stack_depth >= 1) ? stack_mem[stack_depth - 1] : '0;
         nos = (stack_depth >= 2) ? stack_mem[stack_depth - 2] : '0;
         case (op)
            OP_DROP: stack_depth--;
            OP_DUP: begin
               stack_mem[stack_depth] = tos;
               stack_depth++;
            end
            OP_SWAP: begin
               stack_mem[stack_depth - 1] = nos;
               stack_mem[stack_depth - 2] = tos;
            end
            OP_ROT: begin
               third = stack_mem[stack_depth - 3];
               stack_mem[stack_depth - 3] = nos;
               stack_mem[stack_depth - 2] = tos;
               stack_mem[stack_depth - 1] = third;
            end
            OP_OVER: begin
               stack_mem[stack_depth] = nos;
               stack_depth++;
            end
            OP_DOT: begin
               res.kind  = KIND_NUMBER;
               res.value = tos;
               stack_depth--;
            end
            OP_EMIT: begin
               res.kind  = KIND_CHAR;
               res.value = {{(WORD_WIDTH - 8){1'b0}}, tos[7:0]};
               stack_depth--;
            end
            OP_CR: res.kind = KIND_NEWLINE;
            OP_PUSH: begin
               stack_mem[stack_depth] = lit;
               stack_depth++;
            end
            default: begin
               stack_depth -= 2;
               if ((op == OP_DIV || op == OP_MOD) && tos == '0) begin
                  res.status = STAT_DIVZERO;
               end else begin
                  // 64-bit quotient keeps most negative over minus one defined
                  num = $signed(nos);
                  den = $signed(tos);
                  case (op)
                     OP_ADD: r = nos + tos;
                     OP_SUB: r = nos - tos;
                     OP_MUL: r = nos * tos;
                     OP_DIV: r = word_t'(num / den);
                     OP_MOD: r = word_t'(num % den);
                     OP_GT:  r = ($signed(nos) > $signed(tos)) ? {WORD_WIDTH{1'b1}} : '0;
                     OP_LT:  r = ($signed(nos) < $signed(tos)) ? {WORD_WIDTH{1'b1}} : '0;
                     default: r = (nos == tos) ? {WORD_WIDTH{1'b1}} : '0;
                  endcase
                  stack_mem[stack_depth] = r;
                  stack_depth++;
               end
            end
         endcase
      end
      res.depth = DEPTH_W'(stack_depth);
      return res;
   endfunction

   function automatic word_t pick_literal();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return {WORD_WIDTH{1'b1}};
      if (r < 25) return {1'b1, {(WORD_WIDTH - 1){1'b0}}};
      if (r < 30) return {1'b0, {(WORD_WIDTH - 1){1'b1}}};
      if (r < 35) return word_t'(1);
      if (r < 60) return word_t'($urandom_range(0, 32) - 16);
      return word_t'($urandom);
   endfunction

   function automatic logic [OP_W-1:0] pick_word();
      int r;
      r = $urandom_range(0, 99);
      // keep a few operands around so most words do real work
      if (stack_depth < 2 && r < 50) return OP_PUSH;
      if (r < 25) return OP_PUSH;
      if (r < 30) return OP_DUP;
      if (r < 35) return OP_OVER;
      if (r < 40) return OP_SWAP;
      if (r < 45) return OP_ROT;
      if (r < 50) return OP_DROP;
      if (r < 55) return OP_ADD;
      if (r < 60) return OP_SUB;
      if (r < 65) return OP_MUL;
      if (r < 72) return OP_DIV;
      if (r < 79) return OP_MOD;
      if (r < 83) return OP_GT;
      if (r < 87) return OP_LT;
      if (r < 91) return OP_EQ;
      if (r < 94) return OP_DOT;
      if (r < 96) return OP_EMIT;
      if (r < 98) return OP_CR;
      return OP_W'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST));
   endfunction

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_word(input logic [OP_W-1:0] op, input word_t lit,
                            input logic typed_in, input word_result_t typed_res);
      word_result_t res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= lit;
      do @(posedge clock); while (!req_tready);
      res = predict_word(op, lit);
      expected_results.push_back(typed_in ? typed_res : res);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : result_check
      word_result_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser[STATUS_W-1:0];
         got.kind   = rsp_tuser[STATUS_W +: KIND_W];
         got.value  = rsp_tdata[WORD_WIDTH-1:0];
         got.depth  = rsp_tdata[WORD_WIDTH +: DEPTH_W];
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result beat: status %0d kind %0d value %h depth %0d",
                        got.status, got.kind, got.value, got.depth);
         end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status || got.kind !== want.kind ||
                got.value !== want.value || got.depth !== want.depth) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: exp status %0d kind %0d value %h depth %0d, got %0d %0d %h %0d",
                           want.status, want.kind, want.value, want.depth,
                           got.status, got.kind, got.value, got.depth);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int                i, sent, fill_at;
      logic [OP_W-1:0]   op;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_DIRECTED; i++)
         send_word(directed_rows[i].op, directed_rows[i].lit,
                   directed_rows[i].typed_in, directed_rows[i].res);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         send_idle_pct  = send_pct[phase];
         recv_stall_pct = stall_pct[phase];
         fill_at = $urandom_range(0, RANDOM_PER_PHASE / 2);
         sent = 0;
         while (sent < RANDOM_PER_PHASE) begin
            if (sent == fill_at) begin
               // fill the stack, then hit it with growing words
               while (stack_depth < STACK_DEPTH) begin
                  send_word(OP_PUSH, pick_literal(), 1'b0, '0);
                  sent++;
               end
               repeat (3) begin
                  case ($urandom_range(0, 2))
                     0: op = OP_PUSH;
                     1: op = OP_DUP;
                     default: op = OP_OVER;
                  endcase
                  send_word(op, pick_literal(), 1'b0, '0);
                  sent++;
               end
            end
            send_word(pick_word(), pick_literal(), 1'b0, '0);
            sent++;
         end
         // hold off until every result of this phase is back
         req_tvalid <= 1'b0;
         while (expected_results.size() != 0) @(posedge clock);
         @(negedge clock);
      end

      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
